[sv/dtus_pkg.sv]
// Package for the deduplicating timed update scheduler.
// Holds the table entry type, the state and status codes and fixed constants.
// No dependencies.
`default_nettype none

package dtus_pkg;

  // Most due entries that one tick may remove, whatever the register holds.
  localparam int unsigned DUE_CAP = 64;

  // Width of the per-tick limit register and counters.
  localparam int unsigned LIM_W = 7;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_EARLIER   = 3'd1,
    STAT_UNCHANGED = 3'd2,
    STAT_DROPPED   = 3'd3,
    STAT_DUE       = 3'd4,
    STAT_NONE      = 3'd5
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_EMIT
  } state_t;

  // One table entry as held in the table memory.
  typedef struct packed {
    logic               valid;
    logic signed [23:0] x;
    logic signed [15:0] y;
    logic signed [23:0] z;
    logic        [31:0] deadline;
    logic        [31:0] order;
  } entry_t;

endpackage

`default_nettype wire

[sv/dtus_intf.sv]
// Channel interfaces of the scheduler: request, result and register write.
// Depends on nothing; plain valid/ready channels.
`default_nettype none

// Request channel: one schedule or tick command per transaction.
interface dtus_req_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [23:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [23:0] pos_z;
  logic        [7:0]  delay_ticks;

  modport source (output valid, command, pos_x, pos_y, pos_z, delay_ticks, input ready);
  modport sink   (input valid, command, pos_x, pos_y, pos_z, delay_ticks, output ready);
endinterface

// Result channel: one result item per transaction.
interface dtus_rsp_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  status;
  logic signed [23:0] due_x;
  logic signed [15:0] due_y;
  logic signed [23:0] due_z;
  logic               last;
  logic        [8:0]  pending_count;

  modport source (output valid, status, due_x, due_y, due_z, last, pending_count,
                  input ready);
  modport sink   (input valid, status, due_x, due_y, due_z, last, pending_count,
                  output ready);
endinterface

// Register write channel for the per-tick limit.
interface dtus_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] max_due_per_tick;

  modport source (output valid, max_due_per_tick, input ready);
  modport sink   (input valid, max_due_per_tick, output ready);
endinterface

`default_nettype wire

[sv/dtus_table.sv]
// Entry table of the scheduler: one write port, one read port, registered read.
// Depends on dtus_pkg for the entry type.
`default_nettype none

module dtus_table
  import dtus_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire entry_t                     wr_data,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output entry_t                          rd_data
);

  entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[sv/dedup_timed_update_scheduler.sv]
// Top level of the deduplicating timed update scheduler.
// Depends on dtus_pkg, the channel interfaces in dtus_intf.sv and dtus_table.
//
// A table of TABLE_DEPTH pending position updates, each with a deadline
// tick, is kept in one memory and walked one entry per cycle by a single
// compare unit under a small sequencer. After reset the block sweeps the
// table to clear it and takes no request in that time. A schedule
// transaction walks the table until it meets the same position, or to its
// end; the block is idle again in the same cycle that its result is
// offered. A tick transaction makes one walk for every due entry it
// removes, and one more that finds nothing unless the per-tick limit is
// reached first. Each result passes through the S_EMIT state to reach the
// output register, and a tick that removes entries stages its final result
// in S_FLUSH first. The memory's single read port sets the pace of each
// walk, and stalls on the result side hold the sequencer in S_EMIT.
// Results wait in an output register; a request is taken only while the
// sequencer is idle. Register writes are taken at any time and must be
// made while the block is idle.
`default_nettype none

module dedup_timed_update_scheduler
  import dtus_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic clk,
  input  wire logic rst,
  dtus_req_if.sink   req,
  dtus_rsp_if.source rsp,
  dtus_cfg_if.sink   cfg
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned OW = $clog2(TABLE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

  // Control state.
  state_t             state, state_next;
  state_t             ret_state, ret_state_next;
  logic               is_tick, is_tick_next;
  logic [CW-1:0]      rd_cnt, rd_cnt_next;
  logic               chk_vld;
  logic [AW-1:0]      chk_idx;
  logic [31:0]        tick_now, tick_now_next;
  logic [31:0]        insert_stamp, insert_stamp_next;
  logic [OW-1:0]      occ, occ_next;
  logic [LIM_W-1:0]   max_due, lim, lim_next, cnt, cnt_next;
  logic               free_found, free_found_next;
  logic               best_found, best_found_next;
  logic               held_vld, held_vld_next;
  logic               out_vld, out_vld_next;

  // Payload state.
  logic signed [23:0] req_x, req_x_next;
  logic signed [15:0] req_y, req_y_next;
  logic signed [23:0] req_z, req_z_next;
  logic [31:0]        target, target_next;
  logic [AW-1:0]      free_idx, free_idx_next;
  logic [AW-1:0]      best_idx, best_idx_next;
  logic [31:0]        best_age, best_age_next;
  logic signed [23:0] best_x, best_x_next;
  logic signed [15:0] best_y, best_y_next;
  logic signed [23:0] best_z, best_z_next;
  logic signed [23:0] held_x, held_x_next;
  logic signed [15:0] held_y, held_y_next;
  logic signed [23:0] held_z, held_z_next;
  logic [OW-1:0]      held_occ, held_occ_next;
  status_t            res_status, res_status_next;
  logic signed [23:0] res_x, res_x_next;
  logic signed [15:0] res_y, res_y_next;
  logic signed [23:0] res_z, res_z_next;
  logic               res_last, res_last_next;
  logic [OW-1:0]      res_occ, res_occ_next;
  status_t            out_status;
  logic signed [23:0] out_x;
  logic signed [15:0] out_y;
  logic signed [23:0] out_z;
  logic               out_last;
  logic [OW-1:0]      out_occ;

  // Table ports.
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  entry_t             wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  entry_t             rd_data;

  // Shared compare unit outputs.
  logic               pass_end;
  logic               e_match;
  logic               e_earlier;
  logic               e_due;
  logic [31:0]        e_age;
  logic               best_take;
  logic               f_found;
  logic [AW-1:0]      f_idx;
  logic               b_found;
  logic [AW-1:0]      b_idx;
  logic signed [23:0] b_x;
  logic signed [15:0] b_y;
  logic signed [23:0] b_z;
  logic               done;
  logic               emit_go;
  logic [LIM_W-1:0]   cfg_lim;

  // Sign of the 32-bit wrapped difference a - b.
  function automatic logic target_diff_negative(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  dtus_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Handshake outputs.
  assign req.ready         = (state == S_IDLE);
  assign cfg.ready         = 1'b1;
  assign rsp.valid         = out_vld;
  assign rsp.status        = out_status;
  assign rsp.due_x         = out_x;
  assign rsp.due_y         = out_y;
  assign rsp.due_z         = out_z;
  assign rsp.last          = out_last;
  assign rsp.pending_count = 9'(out_occ);

  // Clamp the register value to the range the tick walk supports.
  always_comb begin
    if (max_due == '0) begin
      cfg_lim = LIM_W'(1);
    end else if (max_due > LIM_W'(DUE_CAP)) begin
      cfg_lim = LIM_W'(DUE_CAP);
    end else begin
      cfg_lim = max_due;
    end
  end

  // Compare unit: looks at the entry read in the previous cycle.
  always_comb begin
    e_match   = rd_data.valid && (rd_data.x == req_x) && (rd_data.y == req_y) &&
                (rd_data.z == req_z);
    e_earlier = target_diff_negative(target, rd_data.deadline);
    e_due     = rd_data.valid && !target_diff_negative(tick_now, rd_data.deadline);
    e_age     = insert_stamp - rd_data.order;
    best_take = chk_vld && e_due && (!best_found || (e_age < best_age));
    f_found   = free_found || (chk_vld && !rd_data.valid);
    f_idx     = free_found ? free_idx : chk_idx;
    b_found   = best_found || best_take;
    b_idx     = best_take ? chk_idx    : best_idx;
    b_x       = best_take ? rd_data.x  : best_x;
    b_y       = best_take ? rd_data.y  : best_y;
    b_z       = best_take ? rd_data.z  : best_z;
    pass_end  = chk_vld && (chk_idx == LAST_IDX);
    done      = ((cnt + LIM_W'(1)) == lim);
    emit_go   = !out_vld || rsp.ready;
  end

  // Sequencer: next state, table access and result staging.
  always_comb begin
    state_next        = state;
    ret_state_next    = ret_state;
    is_tick_next      = is_tick;
    rd_cnt_next       = rd_cnt;
    tick_now_next     = tick_now;
    insert_stamp_next = insert_stamp;
    occ_next          = occ;
    lim_next          = lim;
    cnt_next          = cnt;
    free_found_next   = free_found;
    best_found_next   = best_found;
    held_vld_next     = held_vld;
    req_x_next        = req_x;
    req_y_next        = req_y;
    req_z_next        = req_z;
    target_next       = target;
    free_idx_next     = free_idx;
    best_idx_next     = best_idx;
    best_age_next     = best_age;
    best_x_next       = best_x;
    best_y_next       = best_y;
    best_z_next       = best_z;
    held_x_next       = held_x;
    held_y_next       = held_y;
    held_z_next       = held_z;
    held_occ_next     = held_occ;
    res_status_next   = res_status;
    res_x_next        = res_x;
    res_y_next        = res_y;
    res_z_next        = res_z;
    res_last_next     = res_last;
    res_occ_next      = res_occ;
    wr_en             = 1'b0;
    wr_addr           = '0;
    wr_data           = '0;
    rd_en             = 1'b0;
    rd_addr           = rd_cnt[AW-1:0];

    // Result register drains whenever the sink takes it.
    out_vld_next = out_vld && !rsp.ready;

    case (state)
      // Sweep the table once after reset, marking every entry free.
      S_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = rd_cnt[AW-1:0];
        rd_cnt_next = rd_cnt + CW'(1);
        if (rd_cnt[AW-1:0] == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end

      // Take a request and set up the first walk of the table.
      S_IDLE: begin
        if (req.valid) begin
          is_tick_next    = req.command;
          req_x_next      = req.pos_x;
          req_y_next      = req.pos_y;
          req_z_next      = req.pos_z;
          target_next     = tick_now + 32'(req.delay_ticks);
          rd_cnt_next     = '0;
          free_found_next = 1'b0;
          best_found_next = 1'b0;
          held_vld_next   = 1'b0;
          cnt_next        = '0;
          if (req.command) begin
            tick_now_next = tick_now + 32'd1;
            lim_next      = cfg_lim;
          end
          state_next = S_SCAN;
        end
      end

      // Walk the table one entry per cycle.
      S_SCAN: begin
        if (rd_cnt < CW'(TABLE_DEPTH)) begin
          rd_en       = 1'b1;
          rd_cnt_next = rd_cnt + CW'(1);
        end
        if (!is_tick) begin
          // Schedule: stop at the same position, else remember the first free slot.
          free_found_next = f_found;
          free_idx_next   = f_idx;
          res_x_next      = '0;
          res_y_next      = '0;
          res_z_next      = '0;
          res_last_next   = 1'b1;
          res_occ_next    = occ;
          if (chk_vld && e_match) begin
            if (e_earlier) begin
              wr_en            = 1'b1;
              wr_addr          = chk_idx;
              wr_data          = rd_data;
              wr_data.deadline = target;
              res_status_next  = STAT_EARLIER;
            end else begin
              res_status_next  = STAT_UNCHANGED;
            end
            ret_state_next = S_IDLE;
            state_next     = S_EMIT;
          end else if (pass_end) begin
            if (f_found) begin
              wr_en             = 1'b1;
              wr_addr           = f_idx;
              wr_data.valid     = 1'b1;
              wr_data.x         = req_x;
              wr_data.y         = req_y;
              wr_data.z         = req_z;
              wr_data.deadline  = target;
              wr_data.order     = insert_stamp;
              insert_stamp_next = insert_stamp + 32'd1;
              occ_next          = occ + OW'(1);
              res_occ_next      = occ + OW'(1);
              res_status_next   = STAT_INSERTED;
            end else begin
              res_status_next   = STAT_DROPPED;
            end
            ret_state_next = S_IDLE;
            state_next     = S_EMIT;
          end
        end else begin
          // Tick: keep the newest due entry seen so far.
          best_found_next = b_found;
          best_idx_next   = b_idx;
          best_x_next     = b_x;
          best_y_next     = b_y;
          best_z_next     = b_z;
          if (best_take) begin
            best_age_next = e_age;
          end
          if (pass_end) begin
            rd_cnt_next     = '0;
            best_found_next = 1'b0;
            if (b_found) begin
              // Remove it; the previous one can now go out as not last.
              wr_en         = 1'b1;
              wr_addr       = b_idx;
              occ_next      = occ - OW'(1);
              cnt_next      = cnt + LIM_W'(1);
              held_vld_next = 1'b1;
              held_x_next   = b_x;
              held_y_next   = b_y;
              held_z_next   = b_z;
              held_occ_next = occ - OW'(1);
              if (held_vld) begin
                res_status_next = STAT_DUE;
                res_x_next      = held_x;
                res_y_next      = held_y;
                res_z_next      = held_z;
                res_last_next   = 1'b0;
                res_occ_next    = held_occ;
                ret_state_next  = done ? S_FLUSH : S_SCAN;
                state_next      = S_EMIT;
              end else begin
                state_next      = done ? S_FLUSH : S_SCAN;
              end
            end else if (held_vld) begin
              state_next = S_FLUSH;
            end else begin
              res_status_next = STAT_NONE;
              res_x_next      = '0;
              res_y_next      = '0;
              res_z_next      = '0;
              res_last_next   = 1'b1;
              res_occ_next    = occ;
              ret_state_next  = S_IDLE;
              state_next      = S_EMIT;
            end
          end
        end
      end

      // Final due entry of a tick goes out marked last.
      S_FLUSH: begin
        res_status_next = STAT_DUE;
        res_x_next      = held_x;
        res_y_next      = held_y;
        res_z_next      = held_z;
        res_last_next   = 1'b1;
        res_occ_next    = held_occ;
        ret_state_next  = S_IDLE;
        state_next      = S_EMIT;
      end

      // Hand the staged result to the output register once it is free.
      S_EMIT: begin
        if (emit_go) begin
          out_vld_next = 1'b1;
          state_next   = ret_state;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ret_state    <= S_IDLE;
      is_tick      <= 1'b0;
      rd_cnt       <= '0;
      chk_vld      <= 1'b0;
      tick_now     <= '0;
      insert_stamp <= '0;
      occ          <= '0;
      lim          <= LIM_W'(DUE_CAP);
      cnt          <= '0;
      free_found   <= 1'b0;
      best_found   <= 1'b0;
      held_vld     <= 1'b0;
      out_vld      <= 1'b0;
      max_due      <= LIM_W'(DUE_CAP);
    end else begin
      ret_state    <= ret_state_next;
      is_tick      <= is_tick_next;
      rd_cnt       <= rd_cnt_next;
      chk_vld      <= rd_en;
      tick_now     <= tick_now_next;
      insert_stamp <= insert_stamp_next;
      occ          <= occ_next;
      lim          <= lim_next;
      cnt          <= cnt_next;
      free_found   <= free_found_next;
      best_found   <= best_found_next;
      held_vld     <= held_vld_next;
      out_vld      <= out_vld_next;
      if (cfg.valid) begin
        max_due <= cfg.max_due_per_tick;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    chk_idx    <= rd_addr;
    req_x      <= req_x_next;
    req_y      <= req_y_next;
    req_z      <= req_z_next;
    target     <= target_next;
    free_idx   <= free_idx_next;
    best_idx   <= best_idx_next;
    best_age   <= best_age_next;
    best_x     <= best_x_next;
    best_y     <= best_y_next;
    best_z     <= best_z_next;
    held_x     <= held_x_next;
    held_y     <= held_y_next;
    held_z     <= held_z_next;
    held_occ   <= held_occ_next;
    res_status <= res_status_next;
    res_x      <= res_x_next;
    res_y      <= res_y_next;
    res_z      <= res_z_next;
    res_last   <= res_last_next;
    res_occ    <= res_occ_next;
    if (state == S_EMIT && emit_go) begin
      out_status <= res_status;
      out_x      <= res_x;
      out_y      <= res_y;
      out_z      <= res_z;
      out_last   <= res_last;
      out_occ    <= res_occ;
    end
  end

endmodule

`default_nettype wire

[sv/dtus_checker.sv]
// Port-level checks for the scheduler, and the bind that attaches them.
// Depends on dtus_pkg for the status codes.
`default_nettype none

module dtus_checker
  import dtus_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [2:0]  rsp_status,
  input wire logic [23:0] rsp_due_x,
  input wire logic [15:0] rsp_due_y,
  input wire logic [23:0] rsp_due_z,
  input wire logic        rsp_last
);

  // A result waiting to be taken stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result withdrawn before it was taken");

  // Once a request transaction is taken, the block is busy on the next cycle.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while the previous one is still at work");

  // Schedule results and empty ticks are single results with zero coordinates.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != STAT_DUE |->
      rsp_last && rsp_due_x == '0 && rsp_due_y == '0 && rsp_due_z == '0)
    else $error("non-due result not marked last or carries coordinates");

  // No result code outside the defined set is offered.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_status <= STAT_NONE)
    else $error("undefined result status");

endmodule

bind dedup_timed_update_scheduler dtus_checker u_dtus_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_due_x  (rsp.due_x),
  .rsp_due_y  (rsp.due_y),
  .rsp_due_z  (rsp.due_z),
  .rsp_last   (rsp.last)
);

`default_nettype wire
